// ===== src/nsrc_pkg.sv =====
// Package: shared types, protocol codes and checksum helpers for the NAT source rewrite.
`timescale 1ns / 1ps
`default_nettype none

package nsrc_pkg;

  localparam int unsigned ProtoW   = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned PortW    = 16;
  localparam int unsigned CsumW    = 16;
  localparam int unsigned SumW     = 19;

  localparam logic [ProtoW-1:0] PROTO_TCP = 8'd6;
  localparam logic [ProtoW-1:0] PROTO_UDP = 8'd17;
  localparam logic [CsumW-1:0]  CSUM_MASK = 16'hFFFF;

  // Fields listed from the highest bit down so that protocol lands in bits 7:0.
  typedef struct packed {
    logic [PortW-1:0]  mapped_port;
    logic [AddrW-1:0]  outside_addr;
    logic              session_present;
    logic [CsumW-1:0]  l4_checksum_in;
    logic [CsumW-1:0]  ip_checksum_in;
    logic [PortW-1:0]  old_src_port;
    logic [AddrW-1:0]  old_src_addr;
    logic [ProtoW-1:0] protocol;
  } nsrc_in_t;

  typedef struct packed {
    logic              translated;
    logic [CsumW-1:0]  l4_checksum_out;
    logic [CsumW-1:0]  ip_checksum_out;
    logic [PortW-1:0]  new_src_port;
    logic [AddrW-1:0]  new_src_addr;
  } nsrc_out_t;

  localparam int unsigned InW      = $bits(nsrc_in_t);
  localparam int unsigned OutW     = $bits(nsrc_out_t);
  localparam int unsigned InBytesW  = ((InW + 7) / 8) * 8;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  // Fold the end-around carry twice and complement.
  function automatic logic [CsumW-1:0] fold_cpl(input logic [SumW-1:0] s);
    logic [CsumW:0] f1;
    logic [CsumW:0] f2;
    f1 = {1'b0, s[CsumW-1:0]} + {{(CsumW+1-(SumW-CsumW)){1'b0}}, s[SumW-1:CsumW]};
    f2 = {1'b0, f1[CsumW-1:0]} + {{CsumW{1'b0}}, f1[CsumW]};
    return ~f2[CsumW-1:0];
  endfunction

  function automatic logic [CsumW-1:0] upd16(input logic [CsumW-1:0] ck,
                                              input logic [PortW-1:0] oldv,
                                              input logic [PortW-1:0] newv);
    logic [SumW-1:0] s;
    s = {3'b000, ~ck} + {3'b000, ~oldv} + {3'b000, newv};
    return fold_cpl(s);
  endfunction

  function automatic logic [CsumW-1:0] upd32(input logic [CsumW-1:0] ck,
                                              input logic [AddrW-1:0] oldv,
                                              input logic [AddrW-1:0] newv);
    logic [SumW-1:0] s;
    s = {3'b000, ~ck} + {3'b000, ~oldv[15:0]} + {3'b000, ~oldv[31:16]}
      + {3'b000, newv[15:0]} + {3'b000, newv[31:16]};
    return fold_cpl(s);
  endfunction

endpackage

`default_nettype wire

// ===== src/nat_source_rewrite_checksum.sv =====
// Top level: NAT source rewrite with RFC 1624 incremental checksum update.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet header word per cycle and returns one result word for each, in order.
// A word passes an input register, the rewrite and checksum logic, and a result register,
// where its result appears. With the output side ready, one word is accepted every
// cycle; when the output stalls, the input register still takes one more word before
// tready drops. TCP (6) and UDP (17) headers with a session get the outside address
// and port and both checksums updated; a UDP checksum of zero stays zero. All other
// words pass through with translated low.
module nat_source_rewrite_checksum (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // protocol, old_src_addr, old_src_port, ip_checksum_in, l4_checksum_in,
  // session_present, outside_addr, mapped_port, zero fill
  input  wire  [nsrc_pkg::InBytesW-1:0]        s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // new_src_addr, new_src_port, ip_checksum_out, l4_checksum_out, translated, zero fill
  output logic [nsrc_pkg::OutBytesW-1:0]       m_axis_tdata_o
);
  import nsrc_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  nsrc_in_t  s1_data_q;
  logic      s2_valid_q, s2_valid_d;
  nsrc_out_t s2_data_q;
  nsrc_out_t res;
  logic      s2_ready;
  logic      s1_ready;

  assign s2_ready = !s2_valid_q || m_axis_tready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s_axis_tready_o = s1_ready;

  nsrc_rewrite u_rewrite (
    .hdr_i (s1_data_q),
    .res_o (res)
  );

  always_comb begin
    s1_valid_d = s1_ready ? s_axis_tvalid_i : s1_valid_q;
    s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid_i) begin
      s1_data_q <= nsrc_in_t'(s_axis_tdata_i[InW-1:0]);
    end
    if (s2_ready && s1_valid_q) begin
      s2_data_q <= res;
    end
  end

  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tdata_o  = {{(OutBytesW-OutW){1'b0}}, s2_data_q};

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> s1_valid_q)
    else $error("accepted word not held in input register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_data_q))
    else $error("input register lost a word during stall");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_valid_q |-> s_axis_tready_o)
    else $error("input blocked while result register empty");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> s2_valid_q)
    else $error("word not advanced to result register");

endmodule

`default_nettype wire

// ===== src/nsrc_rewrite.sv =====
// Rewrite logic: source address and port swap with incremental checksum update.
`timescale 1ns / 1ps
`default_nettype none

module nsrc_rewrite (
  input  nsrc_pkg::nsrc_in_t  hdr_i,
  output nsrc_pkg::nsrc_out_t res_o
);
  import nsrc_pkg::*;

  logic             is_l4;
  logic             do_xlate;
  logic             keep_l4;
  logic [CsumW-1:0] ip_upd;
  logic [CsumW-1:0] l4_addr_upd;
  logic [CsumW-1:0] l4_upd;

  assign is_l4    = (hdr_i.protocol == PROTO_TCP) || (hdr_i.protocol == PROTO_UDP);
  assign do_xlate = is_l4 && hdr_i.session_present;
  // UDP with checksum absent: keep zero
  assign keep_l4  = (hdr_i.protocol == PROTO_UDP) && (hdr_i.l4_checksum_in == '0);

  assign ip_upd      = upd32(hdr_i.ip_checksum_in, hdr_i.old_src_addr, hdr_i.outside_addr);
  assign l4_addr_upd = upd32(hdr_i.l4_checksum_in, hdr_i.old_src_addr, hdr_i.outside_addr);
  assign l4_upd      = upd16(l4_addr_upd, hdr_i.old_src_port, hdr_i.mapped_port);

  always_comb begin
    if (do_xlate) begin
      res_o.new_src_addr    = hdr_i.outside_addr;
      res_o.new_src_port    = hdr_i.mapped_port;
      res_o.ip_checksum_out = ip_upd;
      res_o.l4_checksum_out = keep_l4 ? hdr_i.l4_checksum_in : l4_upd;
      res_o.translated      = 1'b1;
    end else begin
      res_o.new_src_addr    = hdr_i.old_src_addr;
      res_o.new_src_port    = hdr_i.old_src_port;
      res_o.ip_checksum_out = hdr_i.ip_checksum_in;
      res_o.l4_checksum_out = hdr_i.l4_checksum_in;
      res_o.translated      = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for nat_source_rewrite_checksum: header stream with self-checking rewrite prediction.
`timescale 1ns / 1ps

module tb_top;
  import nsrc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 150;

  localparam logic [ProtoW-1:0] PROTO_HOPOPT   = 8'd0;
  localparam logic [ProtoW-1:0] PROTO_ICMP     = 8'd1;
  localparam logic [ProtoW-1:0] PROTO_CBT      = 8'd7;
  localparam logic [ProtoW-1:0] PROTO_CHAOS    = 8'd16;
  localparam logic [ProtoW-1:0] PROTO_MUX      = 8'd18;
  localparam logic [ProtoW-1:0] PROTO_RESERVED = 8'd255;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 s_axis_tvalid  = 1'b0;
  logic [InBytesW-1:0]  s_axis_tdata   = '0;
  logic                 m_axis_tready  = 1'b0;
  wire                  s_axis_tready;
  wire                  m_axis_tvalid;
  wire  [OutBytesW-1:0] m_axis_tdata;

  nsrc_in_t  header_q[$];
  nsrc_out_t rewritten_q[$];

  logic        in_took     = 1'b0;
  logic        out_took    = 1'b0;
  logic        tx_idle_on  = 1'b1;
  logic        rx_idle_on  = 1'b1;
  int unsigned tx_gap      = 0;
  int unsigned rx_wait     = 0;
  int unsigned rx_draw     = 0;
  int unsigned rx_stall    = 0;
  int unsigned hold_reqs   = 0;
  int unsigned hold_served = 0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;

  nat_source_rewrite_checksum dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [CsumW-1:0] fold_not(input logic [31:0] s);
    logic [31:0] t;
    t = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    return ~t[15:0];
  endfunction

  function automatic logic [CsumW-1:0] adjust_for_addr(input logic [CsumW-1:0] ck,
                                                       input logic [AddrW-1:0] was,
                                                       input logic [AddrW-1:0] now);
    return fold_not({16'h0, ~ck} + {16'h0, ~was[15:0]} + {16'h0, ~was[31:16]}
                    + {16'h0, now[15:0]} + {16'h0, now[31:16]});
  endfunction

  function automatic logic [CsumW-1:0] adjust_for_port(input logic [CsumW-1:0] ck,
                                                       input logic [PortW-1:0] was,
                                                       input logic [PortW-1:0] now);
    return fold_not({16'h0, ~ck} + {16'h0, ~was} + {16'h0, now});
  endfunction

  function automatic nsrc_out_t predict_rewrite(input nsrc_in_t h);
    nsrc_out_t r;
    logic      is_l4;
    is_l4 = (h.protocol == PROTO_TCP) || (h.protocol == PROTO_UDP);
    r.new_src_addr    = h.old_src_addr;
    r.new_src_port    = h.old_src_port;
    r.ip_checksum_out = h.ip_checksum_in;
    r.l4_checksum_out = h.l4_checksum_in;
    r.translated      = 1'b0;
    if (is_l4 && h.session_present) begin
      r.new_src_addr    = h.outside_addr;
      r.new_src_port    = h.mapped_port;
      r.ip_checksum_out = adjust_for_addr(h.ip_checksum_in, h.old_src_addr, h.outside_addr);
      r.translated      = 1'b1;
      if (!(h.protocol == PROTO_UDP && h.l4_checksum_in == '0)) begin
        r.l4_checksum_out = adjust_for_port(
            adjust_for_addr(h.l4_checksum_in, h.old_src_addr, h.outside_addr),
            h.old_src_port, h.mapped_port);
      end
    end
    return r;
  endfunction

  function automatic nsrc_in_t make_header(input logic [ProtoW-1:0] proto,
                                           input logic [AddrW-1:0]  saddr,
                                           input logic [PortW-1:0]  sport,
                                           input logic [CsumW-1:0]  ipck,
                                           input logic [CsumW-1:0]  l4ck,
                                           input logic              sess,
                                           input logic [AddrW-1:0]  oaddr,
                                           input logic [PortW-1:0]  oport);
    nsrc_in_t h;
    h.protocol        = proto;
    h.old_src_addr    = saddr;
    h.old_src_port    = sport;
    h.ip_checksum_in  = ipck;
    h.l4_checksum_in  = l4ck;
    h.session_present = sess;
    h.outside_addr    = oaddr;
    h.mapped_port     = oport;
    return h;
  endfunction

  function automatic nsrc_in_t random_header();
    nsrc_in_t    h;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      h.protocol = PROTO_TCP;
    end else if (pick < 8) begin
      h.protocol = PROTO_UDP;
    end else begin
      h.protocol = 8'($urandom_range(0, 255));
    end
    h.old_src_addr    = $urandom();
    h.old_src_port    = 16'($urandom());
    h.ip_checksum_in  = 16'($urandom());
    h.l4_checksum_in  = ($urandom_range(0, 9) == 0) ? '0 : 16'($urandom());
    h.session_present = ($urandom_range(0, 7) != 0);
    h.outside_addr    = ($urandom_range(0, 15) == 0) ? h.old_src_addr : $urandom();
    h.mapped_port     = ($urandom_range(0, 15) == 0) ? h.old_src_port : 16'($urandom());
    return h;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Offer the next header once the current one is taken and the drawn gap has passed.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_took) begin
      if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (header_q.size() != 0) begin
        s_axis_tdata  <= {{(InBytesW - InW){1'b0}}, header_q.pop_front()};
        s_axis_tvalid <= 1'b1;
        tx_gap = tx_idle_on ? $urandom_range(0, 5) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side per word, or for a long stretch on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_reqs != hold_served) begin
      hold_served = hold_served + 1;
      rx_stall = LongHold;
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (out_took) begin
      rx_draw = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (rx_draw == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        rx_wait = rx_draw - 1;
        m_axis_tready <= 1'b0;
      end
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    nsrc_out_t got;
    nsrc_out_t want;
    in_took  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_took <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OutW-1:0];
      if (rewritten_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
      end else begin
        want = rewritten_q.pop_front();
        check_field("new_src_addr", want.new_src_addr, got.new_src_addr);
        check_field("new_src_port", want.new_src_port, got.new_src_port);
        check_field("ip_checksum_out", want.ip_checksum_out, got.ip_checksum_out);
        check_field("l4_checksum_out", want.l4_checksum_out, got.l4_checksum_out);
        check_field("translated", want.translated, got.translated);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      rewritten_q.push_back(predict_rewrite(s_axis_tdata[InW-1:0]));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_until_drained();
    while (header_q.size() != 0 || s_axis_tvalid || rewritten_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    header_q.push_back(make_header(PROTO_TCP, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 32'h0, 16'h0));
    header_q.push_back(make_header(PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                   32'hFFFF_FFFF, 16'hFFFF));
    header_q.push_back(make_header(PROTO_TCP, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1,
                                   32'hFFFF_FFFF, 16'hFFFF));
    header_q.push_back(make_header(PROTO_UDP, 32'hC0A8_0001, 16'h1234, 16'hB1E6, 16'h0000, 1'b1,
                                   32'hCB00_7105, 16'h4000));
    header_q.push_back(make_header(PROTO_UDP, 32'hC0A8_0001, 16'h1234, 16'hB1E6, 16'h5A3C, 1'b1,
                                   32'hCB00_7105, 16'h4000));
    header_q.push_back(make_header(PROTO_UDP, 32'h0A00_0002, 16'h0035, 16'h1C46, 16'hFFFF, 1'b1,
                                   32'h6440_0001, 16'hFFFF));
    header_q.push_back(make_header(PROTO_TCP, 32'h0A00_0002, 16'h0050, 16'h1C46, 16'h0000, 1'b1,
                                   32'h6440_0001, 16'h8001));
    header_q.push_back(make_header(PROTO_TCP, 32'h0A00_0001, 16'h1F90, 16'h0000, 16'h0000, 1'b1,
                                   32'h0A00_0001, 16'h1F90));
    header_q.push_back(make_header(PROTO_TCP, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1,
                                   32'hFFFF_0001, 16'h0001));
    header_q.push_back(make_header(PROTO_HOPOPT, 32'h0A01_0203, 16'h0400, 16'h1111, 16'h2222,
                                   1'b1, 32'hC633_6401, 16'h9000));
    header_q.push_back(make_header(PROTO_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   1'b1, 32'h0, 16'h0));
    header_q.push_back(make_header(PROTO_CBT, 32'h0A00_0003, 16'h0101, 16'h3333, 16'h4444, 1'b1,
                                   32'h6440_0002, 16'h2020));
    header_q.push_back(make_header(PROTO_CHAOS, 32'h0A00_0004, 16'h0202, 16'h5555, 16'h6666,
                                   1'b1, 32'h6440_0003, 16'h3030));
    header_q.push_back(make_header(PROTO_MUX, 32'h0A00_0005, 16'h0303, 16'h7777, 16'h8888, 1'b1,
                                   32'h6440_0004, 16'h4040));
    header_q.push_back(make_header(PROTO_TCP, 32'h0A00_0006, 16'h0404, 16'h9999, 16'hAAAA, 1'b0,
                                   32'h6440_0005, 16'h5050));
    header_q.push_back(make_header(PROTO_UDP, 32'h0A00_0007, 16'h0505, 16'hBBBB, 16'hCCCC, 1'b0,
                                   32'h6440_0006, 16'h6060));
    header_q.push_back(make_header(PROTO_UDP, 32'h0A00_0008, 16'h0606, 16'hDDDD, 16'h0000, 1'b0,
                                   32'h6440_0007, 16'h7070));
    header_q.push_back(make_header(PROTO_ICMP, 32'h0A00_0009, 16'h0707, 16'hEEEE, 16'h1234, 1'b0,
                                   32'h6440_0008, 16'h8080));
    header_q.push_back(make_header(PROTO_TCP, 32'hA5A5_A5A5, 16'hA5A5, 16'h5A5A, 16'hA5A5, 1'b1,
                                   32'h5A5A_5A5A, 16'h5A5A));
    header_q.push_back(make_header(PROTO_UDP, 32'h5A5A_5A5A, 16'h5A5A, 16'hA5A5, 16'h5A5A, 1'b1,
                                   32'hA5A5_A5A5, 16'hA5A5));
    wait_until_drained();

    // Full rate on both sides.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (250) header_q.push_back(random_header());
    wait_until_drained();

    // Back up the pipe behind a long result stall.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    repeat (250) header_q.push_back(random_header());
    hold_reqs = hold_reqs + 1;
    wait_until_drained();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (250) header_q.push_back(random_header());
    wait_until_drained();

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/nsrc_pkg.sv
src/nsrc_rewrite.sv
src/nat_source_rewrite_checksum.sv
verif/tb_top.sv
